[src/rbe_pkg.sv]
// rbe_pkg: constants, phase codes, controller states and the command/status
// types shared by the blink envelope controller, datapath and checker.
// No dependencies.
package rbe_pkg;

  // Time format: unsigned fixed point with TIME_FRAC_BITS fraction bits
  localparam int TIME_FRAC_BITS = 16;
  localparam int TIME_W         = 32;
  localparam int ELAPSED_W      = 18;
  localparam int LEVEL_W        = 17;
  localparam int LEVEL_FRAC     = 16;
  localparam int PHASE_W        = 2;
  localparam int RAND_W         = 64;
  localparam int QUO_W          = 17;
  localparam int CFG_ADDR_W     = 4;
  localparam int CFG_DATA_W     = 64;

  // Phase lengths, rounded to the time grid
  localparam longint unsigned ONE_SEC     = 64'd1 << TIME_FRAC_BITS;
  localparam longint unsigned CLOSE_LEN_L = (ONE_SEC + 64'd5) / 64'd10;
  localparam longint unsigned HOLD_LEN_L  = (ONE_SEC + 64'd10) / 64'd20;
  localparam longint unsigned OPEN_LEN_L  = (64'd3 * ONE_SEC + 64'd10) / 64'd20;

  localparam logic [TIME_W-1:0] CLOSE_LEN = TIME_W'(CLOSE_LEN_L);
  localparam logic [TIME_W-1:0] HOLD_LEN  = TIME_W'(HOLD_LEN_L);
  localparam logic [TIME_W-1:0] OPEN_LEN  = TIME_W'(OPEN_LEN_L);

  // Ramp division: a ramp time is below OPEN_LEN, so DIV_W bits hold it
  localparam int DIV_W  = $clog2(OPEN_LEN_L);
  localparam int DLEN_W = DIV_W + 1;
  localparam int NUM_W  = DIV_W + LEVEL_FRAC;
  localparam int REM_W  = DIV_W + QUO_W + 1;
  localparam longint unsigned CLOSE_RECIP_L = (64'd1 << (LEVEL_FRAC + DIV_W)) / CLOSE_LEN_L;
  localparam longint unsigned OPEN_RECIP_L  = (64'd1 << (LEVEL_FRAC + DIV_W)) / OPEN_LEN_L;
  localparam logic [31:0] CLOSE_RECIP = 32'(CLOSE_RECIP_L);
  localparam logic [31:0] OPEN_RECIP  = 32'(OPEN_RECIP_L);
  localparam logic [DLEN_W-1:0] CLOSE_DLEN = DLEN_W'(CLOSE_LEN_L);
  localparam logic [DLEN_W-1:0] OPEN_DLEN  = DLEN_W'(OPEN_LEN_L);

  // Random wait: top 24 product bits times 7, scaled to the time grid
  localparam int RAND_TOP    = 24;
  localparam int SCALE_W     = RAND_TOP + 3;
  localparam int SCALE_SHIFT = RAND_TOP - TIME_FRAC_BITS;
  localparam int WAIT_W      = TIME_FRAC_BITS + 3;

  localparam logic [RAND_W-1:0] GOLDEN_MIX = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [RAND_W-1:0] STAR_MULT  = 64'h2545_f491_4f6c_dd1d;

  localparam logic [LEVEL_W-1:0] FULL_OPEN = 17'h1_0000;
  localparam logic [LEVEL_W-1:0] SHUT      = 17'h0_0000;

  // Phase codes
  localparam logic [PHASE_W-1:0] PH_WAIT  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_CLOSE = 2'd1;
  localparam logic [PHASE_W-1:0] PH_HOLD  = 2'd2;
  localparam logic [PHASE_W-1:0] PH_OPEN  = 2'd3;

  // Action codes
  localparam logic ACT_ADVANCE = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  // Register index
  localparam logic REG_SEED = 1'b0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STEP,
    ST_DIV_MUL,
    ST_DIV_FIX,
    ST_MIX,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_SCALE,
    ST_EMIT
  } ctl_state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_STEP,
    DP_DIV_MUL,
    DP_DIV_FIX,
    DP_MIX,
    DP_MUL0,
    DP_MUL1,
    DP_MUL2,
    DP_SCALE,
    DP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic need_draw;
  } dp_sts_t;

endpackage

[src/rbe_if.sv]
// rbe_in_if / rbe_out_if: valid/ready channels for tick transactions and
// openness results. Depend on rbe_pkg for field widths.
interface rbe_in_if;
  logic                           valid;
  logic                           ready;
  logic                           action;
  logic [rbe_pkg::ELAPSED_W-1:0]  elapsed_time;

  modport source (output valid, output action, output elapsed_time, input ready);
  modport sink   (input valid, input action, input elapsed_time, output ready);
endinterface

interface rbe_out_if;
  logic                          valid;
  logic                          ready;
  logic [rbe_pkg::LEVEL_W-1:0]   openness;
  logic [rbe_pkg::PHASE_W-1:0]   phase_now;

  modport source (output valid, output openness, output phase_now, input ready);
  modport sink   (input valid, input openness, input phase_now, output ready);
endinterface

[src/rbe_ctrl.sv]
// rbe_ctrl: sequencing state machine for the blink envelope. Issues one
// datapath command per cycle and owns the input ready and result valid.
// Depends on rbe_pkg.
module rbe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  rbe_pkg::dp_sts_t  sts,
  output rbe_pkg::dp_cmd_t  cmd
);
  import rbe_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       emit_ok;

  // Result register is free when empty or being drained this cycle
  assign emit_ok = !out_valid_r || out_ready;

  // State and valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_STEP;
      end
      ST_STEP: begin
        if (sts.need_div)       state_nxt = ST_DIV_MUL;
        else if (sts.need_draw) state_nxt = ST_MIX;
        else                    state_nxt = ST_EMIT;
      end
      ST_DIV_MUL: state_nxt = ST_DIV_FIX;
      ST_DIV_FIX: state_nxt = ST_EMIT;
      ST_MIX:     state_nxt = ST_MUL0;
      ST_MUL0:    state_nxt = ST_MUL1;
      ST_MUL1:    state_nxt = ST_MUL2;
      ST_MUL2:    state_nxt = ST_SCALE;
      ST_SCALE:   state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (emit_ok) state_nxt = ST_IDLE;
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: datapath command, handshakes
  always_comb begin
    cmd.op        = DP_NOP;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = DP_LOAD;
      end
      ST_STEP:    cmd.op = DP_STEP;
      ST_DIV_MUL: cmd.op = DP_DIV_MUL;
      ST_DIV_FIX: cmd.op = DP_DIV_FIX;
      ST_MIX:     cmd.op = DP_MIX;
      ST_MUL0:    cmd.op = DP_MUL0;
      ST_MUL1:    cmd.op = DP_MUL1;
      ST_MUL2:    cmd.op = DP_MUL2;
      ST_SCALE:   cmd.op = DP_SCALE;
      ST_EMIT: begin
        if (emit_ok) begin
          cmd.op        = DP_EMIT;
          out_valid_nxt = 1'b1;
        end
      end
      default:    cmd.op = DP_NOP;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

[src/rbe_datapath.sv]
// rbe_datapath: phase state, saturating phase timer, xorshift64* generator
// with a shared 32x32 multiplier, ramp divider by reciprocal, result register.
// Depends on rbe_pkg.
module rbe_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rbe_pkg::dp_cmd_t              cmd,
  output rbe_pkg::dp_sts_t              sts,
  input  logic                          in_action,
  input  logic [rbe_pkg::ELAPSED_W-1:0] in_elapsed,
  input  logic [rbe_pkg::RAND_W-1:0]    seed,
  output logic [rbe_pkg::LEVEL_W-1:0]   res_openness,
  output logic [rbe_pkg::PHASE_W-1:0]   res_phase
);
  import rbe_pkg::*;

  // xorshift step, three shift/xor stages
  function automatic logic [RAND_W-1:0] xorshift(input logic [RAND_W-1:0] x);
    logic [RAND_W-1:0] y;
    y = x ^ (x >> 12);
    y = y ^ (y << 25);
    y = y ^ (y >> 27);
    return y;
  endfunction

  // Block state
  logic [RAND_W-1:0]    rand_r;
  logic [PHASE_W-1:0]   phase_r;
  logic [TIME_W-1:0]    tip_r;
  logic [WAIT_W-1:0]    wait_r;
  logic                 first_r;

  // Working registers
  logic                 act_r;
  logic [ELAPSED_W-1:0] elap_r;
  logic [DIV_W-1:0]     tdiv_r;
  logic                 dopen_r;
  logic [RAND_W-1:0]    acc_r;
  logic [LEVEL_W-1:0]   level_r;
  logic [LEVEL_W-1:0]   res_open_r;
  logic [PHASE_W-1:0]   res_phase_r;

  // Phase timer
  logic [TIME_W:0]      t_sum;
  logic [TIME_W-1:0]    t_sat;
  logic                 wait_done, close_done, hold_done, open_done;

  assign t_sum      = {1'b0, tip_r} + (TIME_W+1)'(elap_r);
  assign t_sat      = t_sum[TIME_W] ? {TIME_W{1'b1}} : t_sum[TIME_W-1:0];
  assign wait_done  = t_sat > TIME_W'(wait_r);
  assign close_done = t_sat >= CLOSE_LEN;
  assign hold_done  = t_sat >= HOLD_LEN;
  assign open_done  = t_sat >= OPEN_LEN;

  // Status for the step decision
  always_comb begin
    sts.need_draw = (act_r == ACT_ADVANCE) &&
                    (first_r || (phase_r == PH_OPEN && open_done));
    sts.need_div  = (act_r == ACT_ADVANCE) && !first_r &&
                    ((phase_r == PH_CLOSE && !close_done) ||
                     (phase_r == PH_OPEN && !open_done));
  end

  // Shared 32x32 multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      DP_DIV_MUL: begin
        mul_a = 32'(tdiv_r);
        mul_b = dopen_r ? OPEN_RECIP : CLOSE_RECIP;
      end
      DP_MUL0: begin
        mul_a = rand_r[31:0];
        mul_b = STAR_MULT[31:0];
      end
      DP_MUL1: begin
        mul_a = rand_r[63:32];
        mul_b = STAR_MULT[31:0];
      end
      DP_MUL2: begin
        mul_a = rand_r[31:0];
        mul_b = STAR_MULT[63:32];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Ramp quotient correction: estimate is exact or one low
  logic [QUO_W-1:0]  q_est, q_fix;
  logic [DLEN_W-1:0] dlen;
  logic [REM_W-1:0]  num, qd, rem;

  assign q_est = acc_r[DIV_W +: QUO_W];
  assign dlen  = dopen_r ? OPEN_DLEN : CLOSE_DLEN;
  assign num   = REM_W'({tdiv_r, {LEVEL_FRAC{1'b0}}});
  assign qd    = REM_W'(q_est) * REM_W'(dlen);
  assign rem   = num - qd;
  assign q_fix = (rem >= REM_W'(dlen)) ? q_est + QUO_W'(1) : q_est;

  // Wait scaling: r * 7 shifted to the time grid
  logic [SCALE_W-1:0] r_top, r_x7;

  assign r_top = SCALE_W'(acc_r[RAND_W-1 -: RAND_TOP]);
  assign r_x7  = (r_top << 3) - r_top;

  // Reseed value, never zero
  logic [RAND_W-1:0] mix;

  assign mix = ((seed ^ GOLDEN_MIX) == '0) ? RAND_W'(1) : (seed ^ GOLDEN_MIX);

  // Block state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rand_r  <= GOLDEN_MIX;
      phase_r <= PH_WAIT;
      tip_r   <= '0;
      wait_r  <= '0;
      first_r <= 1'b1;
    end else begin
      case (cmd.op)
        DP_STEP: begin
          if (act_r == ACT_RESTART) begin
            rand_r  <= mix;
            phase_r <= PH_WAIT;
            tip_r   <= '0;
            wait_r  <= '0;
            first_r <= 1'b1;
          end else if (first_r) begin
            first_r <= 1'b0;
          end else begin
            tip_r <= t_sat;
            case (phase_r)
              PH_WAIT: begin
                if (wait_done) begin
                  phase_r <= PH_CLOSE;
                  tip_r   <= '0;
                end
              end
              PH_CLOSE: begin
                if (close_done) begin
                  phase_r <= PH_HOLD;
                  tip_r   <= '0;
                end
              end
              PH_HOLD: begin
                if (hold_done) begin
                  phase_r <= PH_OPEN;
                  tip_r   <= '0;
                end
              end
              PH_OPEN: begin
                if (open_done) begin
                  phase_r <= PH_WAIT;
                  tip_r   <= '0;
                end
              end
              default: phase_r <= PH_WAIT;
            endcase
          end
        end
        DP_MIX:   rand_r <= xorshift(rand_r);
        DP_SCALE: wait_r <= WAIT_W'(r_x7 >> SCALE_SHIFT);
        default:  ;
      endcase
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        act_r  <= in_action;
        elap_r <= in_elapsed;
      end
      DP_STEP: begin
        tdiv_r  <= t_sat[DIV_W-1:0];
        dopen_r <= (phase_r == PH_OPEN);
        if (act_r == ACT_RESTART || first_r) begin
          level_r <= FULL_OPEN;
        end else begin
          case (phase_r)
            PH_WAIT:  level_r <= FULL_OPEN;
            PH_CLOSE: level_r <= SHUT;
            PH_HOLD:  level_r <= SHUT;
            PH_OPEN:  level_r <= FULL_OPEN;
            default:  level_r <= FULL_OPEN;
          endcase
        end
      end
      DP_DIV_MUL: acc_r <= mul_p;
      DP_DIV_FIX: level_r <= dopen_r ? q_fix : FULL_OPEN - q_fix;
      DP_MUL0:    acc_r <= mul_p;
      DP_MUL1:    acc_r[63:32] <= acc_r[63:32] + mul_p[31:0];
      DP_MUL2:    acc_r[63:32] <= acc_r[63:32] + mul_p[31:0];
      DP_EMIT: begin
        res_open_r  <= level_r;
        res_phase_r <= phase_r;
      end
      default: ;
    endcase
  end

  assign res_openness = res_open_r;
  assign res_phase    = res_phase_r;

endmodule

[src/random_blink_envelope.sv]
// random_blink_envelope: top level of the random-interval blink envelope.
// Holds the seed register and APB port; instantiates rbe_ctrl and
// rbe_datapath. Depends on rbe_pkg and the channel interfaces.
//
//  port group   dir   kind        contents
//  in_chan      in    valid/ready action, elapsed_time
//  out_chan     out   valid/ready openness, phase_now
//  APB          in    write/read  seed_value at byte address 0
//
// One tick transaction at a time: after the accepting edge the controller runs STEP and then
// EMIT for a restart or a tick with no ramp point and no draw, STEP, DIV_MUL and DIV_FIX before
// EMIT for a point on a ramp, and STEP, MIX, MUL0, MUL1, MUL2 and SCALE before EMIT when a new
// wait is drawn (xorshift step plus three passes through the shared 32x32 multiplier).
// Reset is synchronous, active low; the generator starts from the mixed zero
// seed. A stalled result holds in its register; the next tick is taken
// once the controller is back in idle.
module random_blink_envelope (
  input  logic                           clk,
  input  logic                           rst_n,
  rbe_in_if.sink                         in_chan,
  rbe_out_if.source                      out_chan,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rbe_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rbe_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [rbe_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import rbe_pkg::*;

  logic [RAND_W-1:0] seed_r;
  logic              cfg_wr;
  dp_cmd_t           cmd;
  dp_sts_t           sts;

  // APB register: index is byte address / 8
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[3] == REG_SEED) ? seed_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_wr && paddr[3] == REG_SEED) begin
      seed_r <= pwdata;
    end
  end

  rbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rbe_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_action    (in_chan.action),
    .in_elapsed   (in_chan.elapsed_time),
    .seed         (seed_r),
    .res_openness (out_chan.openness),
    .res_phase    (out_chan.phase_now)
  );

endmodule

[src/rbe_checker.sv]
// rbe_checker: port-level assertions on the result channel of
// random_blink_envelope, bound to the top level. Depends on rbe_pkg.
module rbe_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rbe_pkg::LEVEL_W-1:0]   openness,
  input logic [rbe_pkg::PHASE_W-1:0]   phase_now
);
  import rbe_pkg::*;

  // A pending result stays until taken
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  // Openness never exceeds fully open
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> openness <= FULL_OPEN)
    else $error("openness above full scale");

  // Wait phase is always reported fully open
  a_wait_open: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && phase_now == PH_WAIT |-> openness == FULL_OPEN)
    else $error("wait phase with eye not fully open");

  // Hold phase is always reported shut
  a_hold_shut: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && phase_now == PH_HOLD |-> openness == SHUT)
    else $error("hold phase with eye not shut");

endmodule

bind random_blink_envelope rbe_checker u_rbe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .openness  (out_chan.openness),
  .phase_now (out_chan.phase_now)
);
